// File: rtl/tbls_pkg.sv
// shared types and codes of the tiled block loop sequencer
package tbls_pkg;

   typedef enum logic [2:0] {
      REG_TRI_MODE   = 3'd0,
      REG_LOOP_ORDER = 3'd1,
      REG_BLOCKS_I   = 3'd2,
      REG_BLOCKS_J   = 3'd3,
      REG_BLOCKS_L   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ORD_IJL = 3'd0,
      ORD_ILJ = 3'd1,
      ORD_JLI = 3'd2,
      ORD_JIL = 3'd3,
      ORD_LIJ = 3'd4,
      ORD_LJI = 3'd5
   } order_type;

   typedef enum logic [2:0] {
      KIND_DIAG  = 3'd0,
      KIND_COL   = 3'd1,
      KIND_ROW   = 3'd2,
      KIND_TRAIL = 3'd3,
      KIND_MULT  = 3'd4
   } kind_type;

   localparam int BLK_W   = 6;
   localparam int IDX_W   = 12;
   localparam int STEP_W  = 18;
   localparam int CSR_W   = 7;

   typedef struct packed {
      logic             tri_mode;
      order_type        order_sel;
      logic [CSR_W-1:0] blocks_i;
      logic [CSR_W-1:0] blocks_j;
      logic [CSR_W-1:0] blocks_l;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [STEP_W-1:0] step;
      logic              last;
   } tuple_ctl_type;

endpackage

// File: rtl/tbls_req_if.sv
// request channel: one restart flag per item
interface tbls_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

// File: rtl/tbls_rsp_if.sv
// response channel: one block tuple with its indices per item
interface tbls_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  row_block;
   logic [5:0]  col_block;
   logic [5:0]  inner_block;
   logic [11:0] left_index;
   logic [11:0] right_index;
   logic [11:0] out_index;
   logic [2:0]  step_kind;
   logic [17:0] step_number;
   logic        last;

   modport source (output valid, output row_block, output col_block, output inner_block,
                   output left_index, output right_index, output out_index,
                   output step_kind, output step_number, output last, input ready);
   modport sink (input valid, input row_block, input col_block, input inner_block,
                 input left_index, input right_index, input out_index,
                 input step_kind, input step_number, input last, output ready);
endinterface

// File: rtl/tbls_cfg.sv
// configuration register file with loop order saturation
module tbls_cfg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [2:0]                csr_index,
   input  logic [tbls_pkg::CSR_W-1:0] csr_wdata,
   output tbls_pkg::cfg_type         cfg
);
   import tbls_pkg::*;

   logic             tri_mode_ff, tri_mode_in;
   logic [2:0]       order_code_ff, order_code_in;
   logic [CSR_W-1:0] blocks_i_ff, blocks_i_in;
   logic [CSR_W-1:0] blocks_j_ff, blocks_j_in;
   logic [CSR_W-1:0] blocks_l_ff, blocks_l_in;

   always_comb begin
      tri_mode_in   = tri_mode_ff;
      order_code_in = order_code_ff;
      blocks_i_in   = blocks_i_ff;
      blocks_j_in   = blocks_j_ff;
      blocks_l_in   = blocks_l_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TRI_MODE:   tri_mode_in   = csr_wdata[0];
            REG_LOOP_ORDER: order_code_in = csr_wdata[2:0];
            REG_BLOCKS_I:   blocks_i_in   = csr_wdata;
            REG_BLOCKS_J:   blocks_j_in   = csr_wdata;
            REG_BLOCKS_L:   blocks_l_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_mode_ff   <= 1'b0;
         order_code_ff <= ORD_IJL;
         blocks_i_ff   <= CSR_W'(1);
         blocks_j_ff   <= CSR_W'(1);
         blocks_l_ff   <= CSR_W'(1);
      end else begin
         tri_mode_ff   <= tri_mode_in;
         order_code_ff <= order_code_in;
         blocks_i_ff   <= blocks_i_in;
         blocks_j_ff   <= blocks_j_in;
         blocks_l_ff   <= blocks_l_in;
      end
   end

   always_comb begin
      cfg.tri_mode  = tri_mode_ff;
      cfg.order_sel = (order_code_ff > ORD_LJI) ? ORD_LJI : order_type'(order_code_ff);
      cfg.blocks_i  = blocks_i_ff;
      cfg.blocks_j  = blocks_j_ff;
      cfg.blocks_l  = blocks_l_ff;
   end

endmodule

// File: rtl/tbls_walker.sv
// loop nest counters and the tuple register
module tbls_walker #(
   parameter int MAX_BLOCKS = 64,
   parameter int CW = $clog2(MAX_BLOCKS),
   parameter int NW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tbls_pkg::cfg_type       cfg,
   tbls_req_if.sink                req_chan,
   output logic                    tup_valid,
   input  logic                    tup_ready,
   output logic [CW-1:0]           tup_i,
   output logic [CW-1:0]           tup_j,
   output logic [CW-1:0]           tup_l,
   output logic [NW-1:0]           tup_cnt_j,
   output logic [NW-1:0]           tup_cnt_l,
   output tbls_pkg::tuple_ctl_type tup_ctl
);
   import tbls_pkg::*;

   function automatic logic [NW-1:0] clamp_f(input logic [CSR_W-1:0] v);
      logic [NW-1:0] r;
      if (v == '0) r = NW'(1);
      else if (int'(v) > MAX_BLOCKS) r = NW'(MAX_BLOCKS);
      else r = NW'(v);
      return r;
   endfunction

   function automatic logic [CW-1:0] in_start_f(input logic tri_m, input order_type sel,
                                                input logic [CW-1:0] o,
                                                input logic [CW-1:0] m);
      logic [CW-1:0] r;
      r = '0;
      if (tri_m) begin
         if (sel == ORD_ILJ || sel == ORD_JLI) r = m;
         else if (sel == ORD_LIJ || sel == ORD_LJI) r = o;
      end
      return r;
   endfunction

   logic [CW-1:0]     outer_ff, outer_in, middle_ff, middle_in, inner_ff, inner_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]     cur_o, cur_m, cur_n, cur_i, cur_j, cur_l;
   logic [STEP_W-1:0] cur_step;
   logic [NW-1:0]     cnt_i, cnt_j, cnt_l, ext_i, ext_j, ext_l;
   logic [NW-1:0]     outer_end, mid_end, in_end, min_om;
   logic              inner_done, mid_done, outer_done, is_last, mid_from_o;
   logic [CW-1:0]     o_next, m_next;
   kind_type          kind;
   logic              accept;

   logic              valid_a_ff, valid_a_in;
   logic [CW-1:0]     i_a_ff, j_a_ff, l_a_ff;
   logic [NW-1:0]     cj_a_ff, cl_a_ff;
   tuple_ctl_type     ctl_a_ff;

   assign req_chan.ready = !valid_a_ff || tup_ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      cur_o    = req_chan.restart ? '0 : outer_ff;
      cur_m    = req_chan.restart ? '0 : middle_ff;
      cur_n    = req_chan.restart ? '0 : inner_ff;
      cur_step = req_chan.restart ? '0 : step_ff;

      cnt_i = clamp_f(cfg.blocks_i);
      cnt_j = cfg.tri_mode ? cnt_i : clamp_f(cfg.blocks_j);
      cnt_l = cfg.tri_mode ? cnt_i : clamp_f(cfg.blocks_l);

      unique case (cfg.order_sel)
         ORD_IJL: begin
            cur_i = cur_o; cur_j = cur_m; cur_l = cur_n;
            ext_i = cnt_i; ext_j = cnt_j; ext_l = cnt_l;
         end
         ORD_ILJ: begin
            cur_i = cur_o; cur_l = cur_m; cur_j = cur_n;
            ext_i = cnt_i; ext_j = cnt_l; ext_l = cnt_j;
         end
         ORD_JLI: begin
            cur_j = cur_o; cur_l = cur_m; cur_i = cur_n;
            ext_i = cnt_j; ext_j = cnt_l; ext_l = cnt_i;
         end
         ORD_JIL: begin
            cur_j = cur_o; cur_i = cur_m; cur_l = cur_n;
            ext_i = cnt_j; ext_j = cnt_i; ext_l = cnt_l;
         end
         ORD_LIJ: begin
            cur_l = cur_o; cur_i = cur_m; cur_j = cur_n;
            ext_i = cnt_l; ext_j = cnt_i; ext_l = cnt_j;
         end
         default: begin
            cur_l = cur_o; cur_j = cur_m; cur_i = cur_n;
            ext_i = cnt_l; ext_j = cnt_j; ext_l = cnt_i;
         end
      endcase

      // ext_i/j/l here hold the outer, middle and inner range ends
      min_om    = NW'((cur_o < cur_m) ? cur_o : cur_m);
      outer_end = ext_i;
      if (cfg.tri_mode && (cfg.order_sel == ORD_ILJ || cfg.order_sel == ORD_JLI))
         mid_end = NW'(cur_o) + NW'(1);
      else
         mid_end = ext_j;
      if (cfg.tri_mode && (cfg.order_sel == ORD_IJL || cfg.order_sel == ORD_JIL))
         in_end = min_om + NW'(1);
      else
         in_end = ext_l;

      inner_done = (NW'(cur_n) + NW'(1)) >= in_end;
      mid_done   = (NW'(cur_m) + NW'(1)) >= mid_end;
      outer_done = (NW'(cur_o) + NW'(1)) >= outer_end;
      is_last    = inner_done && mid_done && outer_done;

      if (!cfg.tri_mode) kind = KIND_MULT;
      else if (cur_i == cur_l && cur_j == cur_l) kind = KIND_DIAG;
      else if (cur_j == cur_l) kind = KIND_COL;
      else if (cur_i == cur_l) kind = KIND_ROW;
      else kind = KIND_TRAIL;

      mid_from_o = cfg.tri_mode && (cfg.order_sel == ORD_LIJ || cfg.order_sel == ORD_LJI);
      o_next     = cur_o + CW'(1);
      m_next     = mid_from_o ? o_next : '0;

      outer_in  = outer_ff;
      middle_in = middle_ff;
      inner_in  = inner_ff;
      step_in   = step_ff;
      if (accept) begin
         if (is_last) begin
            outer_in  = '0;
            middle_in = '0;
            inner_in  = '0;
            step_in   = '0;
         end else begin
            step_in   = cur_step + STEP_W'(1);
            outer_in  = cur_o;
            middle_in = cur_m;
            if (!inner_done) begin
               inner_in = cur_n + CW'(1);
            end else if (!mid_done) begin
               middle_in = cur_m + CW'(1);
               inner_in  = in_start_f(cfg.tri_mode, cfg.order_sel, cur_o, cur_m + CW'(1));
            end else begin
               outer_in  = o_next;
               middle_in = m_next;
               inner_in  = in_start_f(cfg.tri_mode, cfg.order_sel, o_next, m_next);
            end
         end
      end

      valid_a_in = accept || (valid_a_ff && !tup_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff   <= '0;
         middle_ff  <= '0;
         inner_ff   <= '0;
         step_ff    <= '0;
         valid_a_ff <= 1'b0;
      end else begin
         outer_ff   <= outer_in;
         middle_ff  <= middle_in;
         inner_ff   <= inner_in;
         step_ff    <= step_in;
         valid_a_ff <= valid_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         i_a_ff        <= cur_i;
         j_a_ff        <= cur_j;
         l_a_ff        <= cur_l;
         cj_a_ff       <= cnt_j;
         cl_a_ff       <= cnt_l;
         ctl_a_ff.kind <= kind;
         ctl_a_ff.step <= cur_step;
         ctl_a_ff.last <= is_last;
      end
   end

   assign tup_valid = valid_a_ff;
   assign tup_i     = i_a_ff;
   assign tup_j     = j_a_ff;
   assign tup_l     = l_a_ff;
   assign tup_cnt_j = cj_a_ff;
   assign tup_cnt_l = cl_a_ff;
   assign tup_ctl   = ctl_a_ff;

endmodule

// File: rtl/tbls_index.sv
// linear block indices and the result register
module tbls_index #(
   parameter int MAX_BLOCKS = 64,
   parameter int CW = $clog2(MAX_BLOCKS),
   parameter int NW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tup_valid,
   output logic                    tup_ready,
   input  logic [CW-1:0]           tup_i,
   input  logic [CW-1:0]           tup_j,
   input  logic [CW-1:0]           tup_l,
   input  logic [NW-1:0]           tup_cnt_j,
   input  logic [NW-1:0]           tup_cnt_l,
   input  tbls_pkg::tuple_ctl_type tup_ctl,
   tbls_rsp_if.source              rsp_chan
);
   import tbls_pkg::*;

   localparam int PW = CW + NW + 1;

   logic [PW-1:0]     left_full, right_full, out_full;
   logic              load;
   logic              valid_b_ff, valid_b_in;
   logic [BLK_W-1:0]  row_ff, col_ff, inner_ff;
   logic [IDX_W-1:0]  left_ff, right_ff, out_ff;
   kind_type          kind_ff;
   logic [STEP_W-1:0] step_ff;
   logic              last_ff;

   assign tup_ready  = !valid_b_ff || rsp_chan.ready;
   assign load       = tup_valid && tup_ready;
   assign valid_b_in = load || (valid_b_ff && !rsp_chan.ready);

   assign left_full  = PW'(tup_i) * PW'(tup_cnt_l) + PW'(tup_l);
   assign right_full = PW'(tup_l) * PW'(tup_cnt_j) + PW'(tup_j);
   assign out_full   = PW'(tup_i) * PW'(tup_cnt_j) + PW'(tup_j);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff   <= BLK_W'(tup_i);
         col_ff   <= BLK_W'(tup_j);
         inner_ff <= BLK_W'(tup_l);
         left_ff  <= IDX_W'(left_full);
         right_ff <= IDX_W'(right_full);
         out_ff   <= IDX_W'(out_full);
         kind_ff  <= tup_ctl.kind;
         step_ff  <= tup_ctl.step;
         last_ff  <= tup_ctl.last;
      end
   end

   assign rsp_chan.valid       = valid_b_ff;
   assign rsp_chan.row_block   = row_ff;
   assign rsp_chan.col_block   = col_ff;
   assign rsp_chan.inner_block = inner_ff;
   assign rsp_chan.left_index  = left_ff;
   assign rsp_chan.right_index = right_ff;
   assign rsp_chan.out_index   = out_ff;
   assign rsp_chan.step_kind   = kind_ff;
   assign rsp_chan.step_number = step_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// File: rtl/tiled_block_loop_sequencer.sv
// top level of the tiled block loop sequencer
// usage:
//   each item on req_chan advances a three-deep tiled loop nest by one position,
//   or with restart set begins the nest again from its first tuple
//   each accepted item gives exactly one item on rsp_chan: the (i,j,l) block tuple,
//   its three linear block indices, the step kind, the step number and a last flag
//   after the item flagged last the next item wraps to the first tuple
//   csr_wr_en, csr_index, csr_wdata write tri_mode, the loop order and the block counts;
//   write them only while no item is in flight, then send an item with restart
// timing:
//   latency is two cycles from acceptance to the earliest result acceptance: one for
//   the counter step into the tuple register, one for the index multiplies into the result
//   throughput is one item per cycle, set by the single-cycle counter advance
// reset:
//   synchronous reset clears the counters to the first tuple, empties both
//   registers and loads the default configuration (rectangular, ijl, all counts one)
// stall:
//   when rsp_chan.ready is low the result holds, the tuple register fills, and then
//   req_chan.ready drops until the receiver takes the waiting item
module tiled_block_loop_sequencer #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   tbls_req_if.sink                   req_chan,
   tbls_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [tbls_pkg::CSR_W-1:0] csr_wdata
);
   import tbls_pkg::*;

   localparam int CW = $clog2(MAX_BLOCKS);
   localparam int NW = $clog2(MAX_BLOCKS + 1);

   cfg_type       cfg;
   logic          tup_valid, tup_ready;
   logic [CW-1:0] tup_i, tup_j, tup_l;
   logic [NW-1:0] tup_cnt_j, tup_cnt_l;
   tuple_ctl_type tup_ctl;

   tbls_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbls_walker #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .CW         (CW),
      .NW         (NW)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .tup_valid (tup_valid),
      .tup_ready (tup_ready),
      .tup_i     (tup_i),
      .tup_j     (tup_j),
      .tup_l     (tup_l),
      .tup_cnt_j (tup_cnt_j),
      .tup_cnt_l (tup_cnt_l),
      .tup_ctl   (tup_ctl)
   );

   tbls_index #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .CW         (CW),
      .NW         (NW)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .tup_valid (tup_valid),
      .tup_ready (tup_ready),
      .tup_i     (tup_i),
      .tup_j     (tup_j),
      .tup_l     (tup_l),
      .tup_cnt_j (tup_cnt_j),
      .tup_cnt_l (tup_cnt_l),
      .tup_ctl   (tup_ctl),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/tbls_checker.sv
// port-level checks of the sequencer and their binding
module tbls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  row_block,
   input logic [5:0]  col_block,
   input logic [5:0]  inner_block,
   input logic [2:0]  step_kind,
   input logic [17:0] step_number,
   input logic        last
);
   import tbls_pkg::*;

   logic rsp_take;
   logic after_last_ff, after_last_in;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      after_last_in = after_last_ff;
      if (rsp_take) after_last_in = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b0;
      end else begin
         after_last_ff <= after_last_in;
      end
   end

   // a waiting result holds its step and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(step_number) && $stable(last))
      else $error("result changed while stalled");

   // the item after a last item starts the nest again
   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_take && after_last_ff |-> step_number == '0)
      else $error("sequence did not restart at step zero after last");

   // a diagonal factor step lies on the diagonal
   a_diag_tuple: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && step_kind == KIND_DIAG |->
         row_block == inner_block && col_block == inner_block)
      else $error("diagonal step off the diagonal");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tiled_block_loop_sequencer tbls_checker u_tbls_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .row_block   (rsp_chan.row_block),
   .col_block   (rsp_chan.col_block),
   .inner_block (rsp_chan.inner_block),
   .step_kind   (rsp_chan.step_kind),
   .step_number (rsp_chan.step_number),
   .last        (rsp_chan.last)
);
